FILE: src/abf_pkg.sv
// ----------------------------------------------------------------------------
// abf_pkg: shared types and constants for the audio block FIFO
// Function codes and the float to PCM16 conversion.
// ----------------------------------------------------------------------------
package abf_pkg;

	typedef enum logic [1:0] {
		FUNC_HEADER = 2'd0,
		FUNC_PUSH   = 2'd1,
		FUNC_POP    = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	localparam logic signed [15:0] PCM_MAX = 16'sd32767;
	localparam logic signed [15:0] PCM_MIN = -16'sd32768;

	// IEEE single to PCM16: NaN -> 0, |f| >= 1 saturates, else trunc(f*32768).
	function automatic logic [15:0] to_pcm16(input logic [31:0] bits);
		logic        sgn;
		logic [7:0]  ex;
		logic [23:0] man;
		logic [23:0] shv;
		logic [15:0] mag;
		logic [15:0] res;
		sgn = bits[31];
		ex  = bits[30:23];
		man = {1'b1, bits[22:0]};
		shv = '0;
		mag = '0;
		if (ex == 8'hFF && bits[22:0] != 23'd0) begin
			res = '0;
		end else if (ex >= 8'd127) begin
			res = sgn ? PCM_MIN : PCM_MAX;
		end else begin
			// f*32768 = man * 2^(ex-127+15-23); magnitude < 32768
			if (ex >= 8'd112) begin
				shv = man >> (8'd135 - ex);
				mag = shv[15:0];
			end
			res = sgn ? (16'd0 - mag) : mag;
		end
		return res;
	endfunction

endpackage

FILE: src/audio_block_fifo_pcm16.sv
// ----------------------------------------------------------------------------
// audio_block_fifo_pcm16: stereo block FIFO, drop on full, oversize or no samples
// Header, push and pop commands; pop returns PCM16 frames and block metadata.
// ----------------------------------------------------------------------------
// channel  | ports                                      | timing
// command  | start, busy, func, block_frames, ...       | taken when start & !busy
// result   | done, pcm_left ... queued_frames           | one cycle, done strobe
//
// One item per cycle; busy stays low. Each result passes through the
// registered ring/descriptor read, then the conversion and result
// register. Reset clears pointers, counters and control flags only;
// ring contents are undefined until written. The receiver cannot stall.
module audio_block_fifo_pcm16 #(
	parameter int RING_FRAMES = 4096,
	parameter int RING_BLOCKS = 256,
	parameter int MAX_BLOCK   = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic [15:0]        block_frames,
	input  logic               has_samples,
	input  logic [31:0]        left_sample,
	input  logic [31:0]        right_sample,
	output logic               done,
	output logic signed [15:0] pcm_left,
	output logic signed [15:0] pcm_right,
	output logic               frame_valid,
	output logic               last_in_block,
	output logic [63:0]        first_frame_number,
	output logic [31:0]        drops_at_capture,
	output logic [10:0]        block_length,
	output logic               admitted,
	output logic [31:0]        total_dropped_blocks,
	output logic [31:0]        total_dropped_frames,
	output logic [31:0]        total_captured_blocks,
	output logic [12:0]        queued_frames
);

	localparam int FA = $clog2(RING_FRAMES);
	localparam int BA = $clog2(RING_BLOCKS);
	localparam int LW = $clog2(MAX_BLOCK + 1);

	// rings
	logic [63:0]   frame_mem [RING_FRAMES];
	logic [63:0]   dfirst_mem [RING_BLOCKS];
	logic [LW-1:0] dlen_mem [RING_BLOCKS];
	logic [31:0]   dsnap_mem [RING_BLOCKS];

	// pointers and counters
	logic [BA:0]   bwp_q, brp_q;
	logic [FA:0]   fwp_q, frp_q;
	logic [63:0]   prod_q;
	logic [31:0]   dblk_q, dfrm_q, cblk_q, cfrm_q;
	logic          filling_q;
	logic [LW-1:0] left_q, pop_off_q;
	// open block kept in registers so push needs no descriptor read
	logic [LW-1:0] cur_len_q;
	logic [FA-1:0] cur_start_q;
	// start of block at read side
	logic [FA-1:0] rd_start_q;

	assign busy = 1'b0;

	logic acc;
	assign acc = start && !busy;

	logic [BA:0] bused;
	logic [FA:0] fused;
	assign bused = bwp_q - brp_q;
	assign fused = fwp_q - frp_q;

	logic        is_hdr, is_push, is_pop;
	assign is_hdr  = acc && func == abf_pkg::FUNC_HEADER;
	assign is_push = acc && func == abf_pkg::FUNC_PUSH;
	assign is_pop  = acc && func == abf_pkg::FUNC_POP;

	logic nz, fits, room, adm, drop;
	assign nz   = block_frames != 16'd0;
	assign fits = {16'd0, block_frames} <= 32'(MAX_BLOCK);
	assign room = (32'(bused) < 32'(RING_BLOCKS)) &&
		(32'(fused) + {16'd0, block_frames} <= 32'(RING_FRAMES));
	assign adm  = is_hdr && has_samples && nz && fits && room;
	assign drop = is_hdr && nz && !adm;

	logic push_ok, push_last;
	assign push_ok   = is_push && filling_q && left_q != '0;
	assign push_last = push_ok && left_q == LW'(1);

	logic [FA-1:0] push_pos;
	assign push_pos = cur_start_q + FA'(cur_len_q - left_q);

	// head length is read every cycle at the slot the read pointer will
	// hold next; any descriptor write there is followed by at least one
	// push before the block can be popped, so the register is current.
	logic [LW-1:0] head_len_q;
	logic          pop_ok, pop_last;
	logic [BA-1:0] rslot, rslot_nx;
	assign rslot    = brp_q[BA-1:0];
	assign pop_ok   = is_pop && (brp_q != bwp_q);
	assign pop_last = pop_ok && (pop_off_q + LW'(1) >= head_len_q);
	assign rslot_nx = pop_last ? rslot + BA'(1) : rslot;

	logic [FA-1:0] pop_pos;
	assign pop_pos = rd_start_q + FA'(pop_off_q);

	// memory writes
	always_ff @(posedge clk) begin
		if (push_ok) frame_mem[push_pos] <= {right_sample, left_sample};
		if (adm) begin
			dfirst_mem[bwp_q[BA-1:0]] <= prod_q;
			dlen_mem[bwp_q[BA-1:0]]   <= LW'(block_frames);
			dsnap_mem[bwp_q[BA-1:0]]  <= dfrm_q;
		end
	end

	always_ff @(posedge clk) begin
		head_len_q <= dlen_mem[rslot_nx];
	end

	// stage 1: registered reads and item info
	logic [63:0]   frame_s1, first_s1;
	logic [31:0]   snap_s1;
	logic [LW-1:0] len_s1;
	logic          v_s1, pv_s1, last_s1, adm_s1;
	always_ff @(posedge clk) begin
		frame_s1 <= frame_mem[pop_pos];
		first_s1 <= dfirst_mem[rslot];
		snap_s1  <= dsnap_mem[rslot];
		len_s1   <= head_len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bwp_q <= '0; brp_q <= '0; fwp_q <= '0; frp_q <= '0;
			prod_q <= '0; dblk_q <= '0; dfrm_q <= '0; cblk_q <= '0; cfrm_q <= '0;
			filling_q <= 1'b0; left_q <= '0; pop_off_q <= '0;
			cur_len_q <= '0; cur_start_q <= '0; rd_start_q <= '0;
			v_s1 <= 1'b0; pv_s1 <= 1'b0; last_s1 <= 1'b0; adm_s1 <= 1'b0;
		end else begin
			v_s1    <= acc;
			pv_s1   <= pop_ok;
			last_s1 <= pop_last;
			adm_s1  <= adm;
			if (is_hdr) begin
				filling_q <= adm;
				left_q    <= adm ? LW'(block_frames) : '0;
				if (nz) prod_q <= prod_q + 64'(block_frames);
				if (adm) begin
					cur_len_q   <= LW'(block_frames);
					cur_start_q <= fwp_q[FA-1:0];
				end
				if (drop) begin
					dblk_q <= dblk_q + 32'd1;
					dfrm_q <= dfrm_q + 32'(block_frames);
				end
			end
			if (push_ok) begin
				left_q <= left_q - LW'(1);
				if (push_last) begin
					filling_q <= 1'b0;
					fwp_q  <= fwp_q + (FA+1)'(cur_len_q);
					bwp_q  <= bwp_q + (BA+1)'(1);
					cblk_q <= cblk_q + 32'd1;
					cfrm_q <= cfrm_q + 32'(cur_len_q);
				end
			end
			if (pop_ok) begin
				if (pop_last) begin
					pop_off_q  <= '0;
					frp_q      <= frp_q + (FA+1)'(head_len_q);
					rd_start_q <= rd_start_q + FA'(head_len_q);
					brp_q      <= brp_q + (BA+1)'(1);
				end else begin
					pop_off_q <= pop_off_q + LW'(1);
				end
			end
		end
	end

	// counters as seen after the item
	logic [31:0] dblk_s1, dfrm_s1, cblk_s1;
	logic [12:0] used_s1;
	always_ff @(posedge clk) begin
		dblk_s1 <= drop ? dblk_q + 32'd1 : dblk_q;
		dfrm_s1 <= drop ? dfrm_q + 32'(block_frames) : dfrm_q;
		cblk_s1 <= push_last ? cblk_q + 32'd1 : cblk_q;
		used_s1 <= 13'((push_last ? fused + (FA+1)'(cur_len_q) : fused)
			- (pop_last ? (FA+1)'(head_len_q) : (FA+1)'(0)));
	end

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= v_s1;
	end

	always_ff @(posedge clk) begin
		pcm_left              <= pv_s1 ? abf_pkg::to_pcm16(frame_s1[31:0]) : '0;
		pcm_right             <= pv_s1 ? abf_pkg::to_pcm16(frame_s1[63:32]) : '0;
		frame_valid           <= pv_s1;
		last_in_block         <= last_s1;
		first_frame_number    <= pv_s1 ? first_s1 : '0;
		drops_at_capture      <= pv_s1 ? snap_s1 : '0;
		block_length          <= pv_s1 ? 11'(len_s1) : '0;
		admitted              <= adm_s1;
		total_dropped_blocks  <= dblk_s1;
		total_dropped_frames  <= dfrm_s1;
		total_captured_blocks <= cblk_s1;
		queued_frames         <= used_s1;
	end

	ap_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fused) <= 32'(RING_FRAMES)) else $error("frame ring overfilled");
	ap_blk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(bused) <= 32'(RING_BLOCKS)) else $error("block ring overfilled");
	ap_done: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> ##1 done) else $error("missing result");
	ap_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_in_block |-> frame_valid) else $error("last without frame");

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: audio_block_fifo_pcm16 check against a behavioral block FIFO
// Directed table (rejects, extremes, PCM edge values, abandon) then random
// header/push/pop/none sequences with fill and drain phases; every result scored.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NFR = 4096;
	localparam int NBL = 256;
	localparam int MAXB = 1024;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [15:0] pl;
		logic signed [15:0] pr;
		logic               fv;
		logic               last;
		logic [63:0]        ffn;
		logic [31:0]        snap;
		logic [10:0]        blen;
		logic               adm;
		logic [31:0]        dblk;
		logic [31:0]        dfrm;
		logic [31:0]        cblk;
		logic [12:0]        queued;
	} fifo_result_t;

	typedef struct packed {
		abf_pkg::func_t     fn;
		logic [15:0]        n;
		logic               has;
		logic [31:0]        l;
		logic [31:0]        r;
		logic               typed;
		logic signed [15:0] el;
		logic signed [15:0] er;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] func = abf_pkg::FUNC_NONE;
	logic [15:0] block_frames = '0;
	logic has_samples = 1'b0;
	logic [31:0] left_sample = '0;
	logic [31:0] right_sample = '0;
	logic done;
	logic signed [15:0] pcm_left, pcm_right;
	logic frame_valid, last_in_block, admitted;
	logic [63:0] first_frame_number;
	logic [31:0] drops_at_capture, total_dropped_blocks, total_dropped_frames;
	logic [31:0] total_captured_blocks;
	logic [10:0] block_length;
	logic [12:0] queued_frames;

	audio_block_fifo_pcm16 DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.block_frames(block_frames), .has_samples(has_samples),
		.left_sample(left_sample), .right_sample(right_sample), .done(done),
		.pcm_left(pcm_left), .pcm_right(pcm_right), .frame_valid(frame_valid),
		.last_in_block(last_in_block), .first_frame_number(first_frame_number),
		.drops_at_capture(drops_at_capture), .block_length(block_length),
		.admitted(admitted), .total_dropped_blocks(total_dropped_blocks),
		.total_dropped_frames(total_dropped_frames),
		.total_captured_blocks(total_captured_blocks), .queued_frames(queued_frames)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// behavioral copy of the FIFO state
	logic [63:0] frames_mem [NFR];
	logic [63:0] blk_first [NBL];
	logic [10:0] blk_len [NBL];
	logic [31:0] blk_snap [NBL];
	logic [11:0] blk_base [NBL];
	logic [8:0]  blk_wr, blk_rd;
	logic [12:0] frm_wr, frm_rd;
	logic [63:0] frame_no;
	logic [31:0] drop_blocks, drop_frames, cap_blocks;
	logic        filling;
	logic [10:0] to_push, rd_ofs;

	fifo_result_t expected_q [$];
	int mismatches = 0;
	int cycles = 0;
	int item_no = 0;
	logic typed_pending = 1'b0;
	logic signed [15:0] typed_l, typed_r;

	function automatic logic signed [15:0] pcm_of(input logic [31:0] b);
		int e;
		logic [23:0] m;
		logic signed [15:0] mag;
		e = b[30:23];
		m = {1'b1, b[22:0]};
		if (e == 255 && b[22:0] != 0) return 16'sd0;
		if (e >= 127) return b[31] ? -16'sd32768 : 16'sd32767;
		mag = (e < 112) ? 16'sd0 : 16'(m >> (135 - e));
		return b[31] ? -mag : mag;
	endfunction

	task automatic predict_fifo(input logic [1:0] fn, input logic [15:0] n,
			input logic hs, input logic [31:0] lb, input logic [31:0] rb,
			output fifo_result_t res);
		logic [7:0]  ws;
		logic [7:0]  rs;
		logic [11:0] pos;
		logic [63:0] fr;
		logic [10:0] len;
		ws = blk_wr[7:0];
		res = '0;
		case (fn)
			abf_pkg::FUNC_HEADER: begin
				res.adm = 1'b0;
				filling = 1'b0;
				to_push = '0;
				if (n != 0) begin
					if (hs && n <= MAXB && 9'(blk_wr - blk_rd) < NBL &&
							int'(13'(frm_wr - frm_rd)) <= NFR - int'(n)) begin
						blk_first[ws] = frame_no;
						blk_len[ws] = n[10:0];
						blk_snap[ws] = drop_frames;
						blk_base[ws] = frm_wr[11:0];
						filling = 1'b1;
						to_push = n[10:0];
						res.adm = 1'b1;
					end else begin
						drop_blocks++;
						drop_frames += n;
					end
					frame_no += n;
				end
			end
			abf_pkg::FUNC_PUSH: begin
				if (filling && to_push != 0) begin
					len = blk_len[ws];
					pos = blk_base[ws] + 12'(len - to_push);
					frames_mem[pos] = {rb, lb};
					to_push--;
					if (to_push == 0) begin
						filling = 1'b0;
						frm_wr += len;
						blk_wr++;
						cap_blocks++;
					end
				end
			end
			abf_pkg::FUNC_POP: begin
				if (blk_rd != blk_wr) begin
					rs = blk_rd[7:0];
					len = blk_len[rs];
					fr = frames_mem[blk_base[rs] + 12'(rd_ofs)];
					res.pl = pcm_of(fr[31:0]);
					res.pr = pcm_of(fr[63:32]);
					res.fv = 1'b1;
					res.ffn = blk_first[rs];
					res.snap = blk_snap[rs];
					res.blen = len;
					rd_ofs++;
					if (rd_ofs >= len) begin
						res.last = 1'b1;
						rd_ofs = '0;
						frm_rd += len;
						blk_rd++;
					end
				end
			end
			default: ;
		endcase
		res.dblk = drop_blocks;
		res.dfrm = drop_frames;
		res.cblk = cap_blocks;
		res.queued = 13'(frm_wr - frm_rd);
	endtask

	always @(posedge clk) begin
		fifo_result_t got, want;
		if (arst_n) begin
			cycles++;
			if (done) begin
				got = '{pcm_left, pcm_right, frame_valid, last_in_block,
					first_frame_number, drops_at_capture, block_length, admitted,
					total_dropped_blocks, total_dropped_frames, total_captured_blocks,
					queued_frames};
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", got);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch\n  exp %p\n  got %p", want, got);
					end
				end
			end
			if (start && !busy) begin
				predict_fifo(func, block_frames, has_samples, left_sample,
					right_sample, want);
				if (typed_pending) begin
					want.pl = typed_l;
					want.pr = typed_r;
				end
				expected_q.push_back(want);
			end
		end
	end

	task automatic send_item(input cmd_row_t c);
		@(negedge clk);
		while (!(item_no >= 600 && item_no < 900) && $urandom_range(99) < 24) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		func <= c.fn;
		block_frames <= c.n;
		has_samples <= c.has;
		left_sample <= c.l;
		right_sample <= c.r;
		typed_pending <= c.typed;
		typed_l <= c.el;
		typed_r <= c.er;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		item_no++;
	endtask

	function automatic cmd_row_t mk(input abf_pkg::func_t fn, input logic [15:0] n,
			input logic hs, input logic [31:0] l, input logic [31:0] r,
			input logic t = 1'b0, input logic signed [15:0] el = 0,
			input logic signed [15:0] er = 0);
		return '{fn, n, hs, l, r, t, el, er};
	endfunction

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(7))
			0: return $urandom();
			1: return {1'($urandom_range(1)), 8'hFF, 23'($urandom())};
			2: return {1'($urandom_range(1)), 8'($urandom_range(127, 135)),
				23'($urandom())};
			3: return {1'($urandom_range(1)), 8'($urandom_range(0, 111)),
				23'($urandom())};
			default: return {1'($urandom_range(1)), 8'($urandom_range(112, 126)),
				23'($urandom())};
		endcase
	endfunction

	initial begin
		cmd_row_t plan [$];
		cmd_row_t c;
		int pend;
		logic fill_phase;
		logic [15:0] n;
		frame_no = '0; blk_wr = '0; blk_rd = '0; frm_wr = '0; frm_rd = '0;
		drop_blocks = '0; drop_frames = '0; cap_blocks = '0;
		filling = 1'b0; to_push = '0; rd_ofs = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		plan.push_back(mk(abf_pkg::FUNC_POP, 0, 0, 0, 0));
		plan.push_back(mk(abf_pkg::FUNC_NONE, 16'hFFFF, 1, 32'hFFFFFFFF, 32'hFFFFFFFF));
		plan.push_back(mk(abf_pkg::FUNC_PUSH, 0, 0, 32'h3F800000, 32'h3F800000));
		plan.push_back(mk(abf_pkg::FUNC_HEADER, 0, 1, 0, 0));
		plan.push_back(mk(abf_pkg::FUNC_HEADER, 5, 0, 0, 0));
		plan.push_back(mk(abf_pkg::FUNC_HEADER, 1025, 1, 0, 0));
		plan.push_back(mk(abf_pkg::FUNC_HEADER, 16'hFFFF, 1, 0, 0));
		plan.push_back(mk(abf_pkg::FUNC_HEADER, 4, 1, 0, 0));
		plan.push_back(mk(abf_pkg::FUNC_PUSH, 0, 0, 32'h3F800000, 32'hBF800000));
		plan.push_back(mk(abf_pkg::FUNC_PUSH, 0, 0, 32'h7FC00000, 32'h3F000000));
		plan.push_back(mk(abf_pkg::FUNC_PUSH, 0, 0, 32'hBF000000, 32'h7F800000));
		plan.push_back(mk(abf_pkg::FUNC_PUSH, 0, 0, 32'hFFFFFFFF, 32'h00000001));
		plan.push_back(mk(abf_pkg::FUNC_HEADER, 2, 1, 0, 0));
		plan.push_back(mk(abf_pkg::FUNC_PUSH, 0, 0, 32'h3F7FFFFF, 32'h0));
		// new header abandons the two-frame block
		plan.push_back(mk(abf_pkg::FUNC_HEADER, 1, 1, 0, 0));
		plan.push_back(mk(abf_pkg::FUNC_PUSH, 0, 0, 32'h80000000, 32'hFF800000));
		plan.push_back(mk(abf_pkg::FUNC_POP, 0, 0, 0, 0, 1, 32767, -32768));
		plan.push_back(mk(abf_pkg::FUNC_POP, 0, 0, 0, 0, 1, 0, 16384));
		plan.push_back(mk(abf_pkg::FUNC_POP, 0, 0, 0, 0, 1, -16384, 32767));
		plan.push_back(mk(abf_pkg::FUNC_POP, 0, 0, 0, 0, 1, 0, 0));
		plan.push_back(mk(abf_pkg::FUNC_POP, 0, 0, 0, 0, 1, 0, -32768));
		plan.push_back(mk(abf_pkg::FUNC_POP, 0, 0, 0, 0, 1, 0, 0));
		foreach (plan[i]) send_item(plan[i]);

		pend = 0;
		fill_phase = 1'b1;
		for (int k = 0; k < 1500; k++) begin
			if (k % 200 == 0) fill_phase = !fill_phase;
			c = mk(abf_pkg::FUNC_POP, 16'($urandom()), 1'($urandom_range(1)),
				rand_sample(), rand_sample());
			if (pend > 0 && $urandom_range(99) < 96) begin
				c.fn = abf_pkg::FUNC_PUSH;
				pend--;
			end else if ($urandom_range(99) < (fill_phase ? 8 : 65)) begin
				c.fn = abf_pkg::FUNC_POP;
			end else if ($urandom_range(99) < 6) begin
				c.fn = $urandom_range(1) ? abf_pkg::FUNC_NONE : abf_pkg::FUNC_PUSH;
			end else begin
				c.fn = abf_pkg::FUNC_HEADER;
				case ($urandom_range(29))
					0: n = 16'($urandom_range(256, MAXB));
					1: n = 16'($urandom());
					2: n = 16'd0;
					3: n = 16'(MAXB);
					default: n = 16'($urandom_range(1, 8));
				endcase
				c.n = n;
				c.has = ($urandom_range(19) != 0);
				pend = (c.has && n <= MAXB) ? n : 0;
			end
			send_item(c);
		end
		@(negedge clk);
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
